### sv/ps2mt_pkg.sv
// Package for the PS/2 mouse packet tracker: widths, register indexes, opcodes
// and the position clamp helper. No dependencies.
`default_nettype none

package ps2mt_pkg;

  localparam int unsigned POS_BITS = 12;
  localparam int unsigned POS_SUM_W = POS_BITS + 2;
  localparam int unsigned POS_MAX = (2 ** POS_BITS) - 1;

  localparam int unsigned LIM_W = 12;
  localparam int unsigned TMO_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned OUT_POS_W = 12;
  localparam int unsigned WHEEL_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam logic [LIM_W-1:0] X_LIMIT_RST = 12'd639;
  localparam logic [LIM_W-1:0] Y_LIMIT_RST = 12'd479;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 8'd20;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int unsigned X_SIGN_BIT = 4;
  localparam int unsigned Y_SIGN_BIT = 5;

  function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [POS_SUM_W-1:0] v,
                                                    input logic [LIM_W-1:0] lim);
    logic [POS_BITS-1:0] top;
    logic [POS_BITS-1:0] res;
    if (32'(lim) > POS_MAX) begin
      top = POS_BITS'(POS_MAX);
    end else begin
      top = POS_BITS'(lim);
    end
    if (v[POS_SUM_W-1]) begin
      res = '0;
    end else if (v > $signed({2'b00, top})) begin
      res = top;
    end else begin
      res = v[POS_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker top level: input register, packet/position update
// and output register. Depends on ps2mt_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries opcode_i (0 = mouse byte,
//   1 = frame tick) and data_byte_i. Every input transaction yields exactly
//   one output transaction (out_valid_o/out_ready_i) with the pointer
//   position, wheel count, button byte, packet_done, four_byte_mode and
//   resync as they stand after that item.
//   Each accepted item moves from the input register to the output register,
//   where the outputs show it. Throughput: one item per cycle while the output
//   is not stalled; the state is updated as the item moves into the output
//   register. When the receiver stalls, the output register holds and the input
//   register still takes one more item; after that in_ready_o drops until
//   the output is taken.
//   Configuration (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is
//   always ready: index 0 x limit, 1 y limit, 2 timeout ticks; other
//   indexes are ignored. Write only while no transaction is in flight.
//   Reset clears positions, wheel, buttons, packet progress and stall count,
//   selects three-byte packets and loads limits 639/479 and timeout 20.
`default_nettype none

module ps2_mouse_packet_tracker (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 opcode_i,
  input  wire  [7:0]                          data_byte_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [ps2mt_pkg::OUT_POS_W-1:0]     pointer_x_o,
  output logic [ps2mt_pkg::OUT_POS_W-1:0]     pointer_y_o,
  output logic signed [ps2mt_pkg::WHEEL_W-1:0] wheel_z_o,
  output logic [7:0]                          button_byte_o,
  output logic                                packet_done_o,
  output logic                                four_byte_mode_o,
  output logic                                resync_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [ps2mt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [ps2mt_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ps2mt_pkg::*;

  // configuration
  logic [LIM_W-1:0] x_limit_q, x_limit_d;
  logic [LIM_W-1:0] y_limit_q, y_limit_d;
  logic [TMO_W-1:0] timeout_q, timeout_d;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic       s1_op_q;
  logic [7:0] s1_byte_q;

  // tracker state
  logic [1:0]          byte_idx_q, byte_idx_d;
  logic [7:0]          held_q [3];
  logic [7:0]          held_d [3];
  logic [POS_BITS-1:0] pos_x_q, pos_x_d;
  logic [POS_BITS-1:0] pos_y_q, pos_y_d;
  logic [WHEEL_W-1:0]  pos_z_q, pos_z_d;
  logic [7:0]          buttons_q, buttons_d;
  logic [TMO_W-1:0]    stall_q, stall_d;
  logic                wheel_mode_q, wheel_mode_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [OUT_POS_W-1:0] out_x_q;
  logic [OUT_POS_W-1:0] out_y_q;
  logic [WHEEL_W-1:0]   out_z_q;
  logic [7:0]           out_btn_q;
  logic                 out_done_q;
  logic                 out_mode_q;
  logic                 out_resync_q;

  logic advance;
  logic fire;
  logic in_fire;
  logic done;
  logic dropped;
  logic [1:0] last_idx;
  logic signed [8:0] dx;
  logic signed [8:0] dy;
  logic signed [POS_SUM_W-1:0] sum_x;
  logic signed [POS_SUM_W-1:0] sum_y;
  logic [WHEEL_W-1:0] wheel_add;
  logic [TMO_W-1:0] stall_inc;

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign in_fire     = in_valid_i && in_ready_o;
  assign fire        = s1_valid_q && advance;
  assign s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    x_limit_d = x_limit_q;
    y_limit_d = y_limit_q;
    timeout_d = timeout_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_X_LIMIT: x_limit_d = cfg_data_i[LIM_W-1:0];
        REG_Y_LIMIT: y_limit_d = cfg_data_i[LIM_W-1:0];
        REG_TIMEOUT: timeout_d = cfg_data_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  assign last_idx  = wheel_mode_q ? 2'd3 : 2'd2;
  assign dx        = $signed({held_q[0][X_SIGN_BIT], held_q[1]});
  assign dy        = $signed({held_q[0][Y_SIGN_BIT], held_q[2]});
  assign sum_x     = $signed({2'b00, pos_x_q}) + POS_SUM_W'(dx);
  assign sum_y     = $signed({2'b00, pos_y_q}) - POS_SUM_W'(dy);
  assign wheel_add = {{(WHEEL_W - 4){s1_byte_q[3]}}, s1_byte_q[3:0]};
  assign stall_inc = (stall_q == '1) ? stall_q : stall_q + 1'b1;

  always_comb begin
    byte_idx_d   = byte_idx_q;
    held_d       = held_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    pos_z_d      = pos_z_q;
    buttons_d    = buttons_q;
    stall_d      = stall_q;
    wheel_mode_d = wheel_mode_q;
    done         = 1'b0;
    dropped      = 1'b0;
    if (fire) begin
      if (s1_op_q == OP_BYTE) begin
        if (byte_idx_q >= last_idx) begin
          done       = 1'b1;
          byte_idx_d = '0;
          buttons_d  = held_q[0];
          pos_x_d    = clamp_pos(sum_x, x_limit_q);
          pos_y_d    = clamp_pos(sum_y, y_limit_q);
          stall_d    = '0;
          if (wheel_mode_q) begin
            pos_z_d = pos_z_q + wheel_add;
          end
        end else begin
          held_d[byte_idx_q] = s1_byte_q;
          byte_idx_d         = byte_idx_q + 1'b1;
        end
      end else if (byte_idx_q != '0) begin
        stall_d = stall_inc;
        if (stall_inc >= timeout_q) begin
          byte_idx_d   = '0;
          stall_d      = '0;
          wheel_mode_d = !wheel_mode_q;
          dropped      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q    <= X_LIMIT_RST;
      y_limit_q    <= Y_LIMIT_RST;
      timeout_q    <= TIMEOUT_RST;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      byte_idx_q   <= '0;
      held_q       <= '{8'h00, 8'h00, 8'h00};
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      pos_z_q      <= '0;
      buttons_q    <= '0;
      stall_q      <= '0;
      wheel_mode_q <= 1'b0;
    end else begin
      x_limit_q    <= x_limit_d;
      y_limit_q    <= y_limit_d;
      timeout_q    <= timeout_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      byte_idx_q   <= byte_idx_d;
      held_q       <= held_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      pos_z_q      <= pos_z_d;
      buttons_q    <= buttons_d;
      stall_q      <= stall_d;
      wheel_mode_q <= wheel_mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= opcode_i;
      s1_byte_q <= data_byte_i;
    end
    if (fire) begin
      out_x_q      <= OUT_POS_W'(pos_x_d);
      out_y_q      <= OUT_POS_W'(pos_y_d);
      out_z_q      <= pos_z_d;
      out_btn_q    <= buttons_d;
      out_done_q   <= done;
      out_mode_q   <= wheel_mode_d;
      out_resync_q <= dropped;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pointer_x_o      = out_x_q;
  assign pointer_y_o      = out_y_q;
  assign wheel_z_o        = $signed(out_z_q);
  assign button_byte_o    = out_btn_q;
  assign packet_done_o    = out_done_q;
  assign four_byte_mode_o = out_mode_q;
  assign resync_o         = out_resync_q;

endmodule

`default_nettype wire

### sv/ps2mt_checker.sv
// Port-level checks for the PS/2 mouse packet tracker, bound to the top level.
// Depends on ps2mt_pkg and ps2_mouse_packet_tracker.
`default_nettype none

module ps2mt_checker (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  in_ready_o,
  input wire                                  out_valid_o,
  input wire                                  out_ready_i,
  input wire  [ps2mt_pkg::OUT_POS_W-1:0]      pointer_x_o,
  input wire  [ps2mt_pkg::OUT_POS_W-1:0]      pointer_y_o,
  input wire  signed [ps2mt_pkg::WHEEL_W-1:0] wheel_z_o,
  input wire  [7:0]                           button_byte_o,
  input wire                                  packet_done_o,
  input wire                                  four_byte_mode_o,
  input wire                                  resync_o
);
  import ps2mt_pkg::*;

  a_done_resync_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(packet_done_o && resync_o))
    else $error("packet_done and resync in the same transaction");

  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(pointer_x_o) &&
      $stable(pointer_y_o) && $stable(wheel_z_o) && $stable(four_byte_mode_o) &&
      $stable(button_byte_o) && $stable(packet_done_o) && $stable(resync_o)))
    else $error("stalled output transaction changed");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (.*);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for ps2_mouse_packet_tracker: a directed packet table, then random
// byte/tick traffic in several register and flow-control phases, each result
// checked against a typed row or the bench tracker. Depends on ps2mt_pkg, DUT.

module testbench;
  import ps2mt_pkg::*;

  typedef struct packed {
    logic [OUT_POS_W-1:0] px;
    logic [OUT_POS_W-1:0] py;
    logic [WHEEL_W-1:0]   wz;
    logic [7:0]           btn;
    logic                 done;
    logic                 wmode;
    logic                 drop;
  } report_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       typed;
    report_t    want;
  } row_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int NUM_ROWS = 25;
  localparam int NUM_PHASES = 6;

  // typed rows: known outcome after reset; the rest go through the tracker
  localparam row_t ROWS [NUM_ROWS] = '{
    '{OP_TICK, 8'h00, 1'b1, '{12'd0, 12'd0, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_BYTE, 8'h08, 1'b1, '{12'd0, 12'd0, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_BYTE, 8'hFF, 1'b1, '{12'd0, 12'd0, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_BYTE, 8'h00, 1'b1, '{12'd255, 12'd0, 16'h0000, 8'h08, 1'b1, 1'b0, 1'b0}},
    '{OP_BYTE, 8'hC8, 1'b0, '0},
    '{OP_BYTE, 8'hFF, 1'b0, '0},
    '{OP_BYTE, 8'h80, 1'b1, '{12'd510, 12'd0, 16'h0000, 8'hC8, 1'b1, 1'b0, 1'b0}},
    '{OP_BYTE, 8'h38, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b1, '{12'd254, 12'd256, 16'h0000, 8'h38, 1'b1, 1'b0, 1'b0}},
    '{OP_BYTE, 8'h18, 1'b0, '0},
    '{OP_BYTE, 8'h01, 1'b0, '0},
    '{OP_BYTE, 8'h7F, 1'b1, '{12'd0, 12'd256, 16'h0000, 8'h18, 1'b1, 1'b0, 1'b0}},
    '{OP_BYTE, 8'h09, 1'b0, '0},
    '{OP_TICK, 8'hFF, 1'b0, '0},
    '{OP_TICK, 8'h00, 1'b1, '{12'd0, 12'd256, 16'h0000, 8'h18, 1'b0, 1'b1, 1'b1}},
    '{OP_BYTE, 8'h08, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0},
    '{OP_BYTE, 8'h00, 1'b0, '0},
    '{OP_BYTE, 8'hF8, 1'b1, '{12'd0, 12'd256, 16'hFFF8, 8'h08, 1'b1, 1'b1, 1'b0}},
    '{OP_BYTE, 8'h3A, 1'b0, '0},
    '{OP_BYTE, 8'hFF, 1'b0, '0},
    '{OP_BYTE, 8'hFF, 1'b0, '0},
    '{OP_BYTE, 8'h07, 1'b0, '0},
    '{OP_TICK, 8'h5A, 1'b0, '0}
  };

  localparam int PH_ITEMS [NUM_PHASES] = '{150, 150, 150, 300, 150, 150};
  localparam logic [CFG_DATA_W-1:0] PH_XLIM [NUM_PHASES] =
    '{12'd639, 12'd0, 12'd4095, 12'd100, 12'd4095, 12'd2047};
  localparam logic [CFG_DATA_W-1:0] PH_YLIM [NUM_PHASES] =
    '{12'd479, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd1024};
  localparam logic [CFG_DATA_W-1:0] PH_TMO [NUM_PHASES] =
    '{12'd3, 12'd1, 12'd0, 12'hFFF, 12'd8, 12'd5};
  localparam int PH_SND [NUM_PHASES] = '{0, 58, 0, 26, 0, 26};
  localparam int PH_RCV [NUM_PHASES] = '{0, 0, 58, 26, 58, 26};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  opcode_i = OP_BYTE;
  logic [7:0]            data_byte_i = 8'h00;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OUT_POS_W-1:0]  pointer_x_o;
  logic [OUT_POS_W-1:0]  pointer_y_o;
  logic signed [WHEEL_W-1:0] wheel_z_o;
  logic [7:0]            button_byte_o;
  logic                  packet_done_o;
  logic                  four_byte_mode_o;
  logic                  resync_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_X_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // tracker state and register shadow
  logic [1:0]            trk_index = 2'd0;
  logic [7:0]            trk_held [3] = '{8'h00, 8'h00, 8'h00};
  logic [OUT_POS_W-1:0]  trk_x = '0;
  logic [OUT_POS_W-1:0]  trk_y = '0;
  logic [WHEEL_W-1:0]    trk_z = '0;
  logic [7:0]            trk_buttons = 8'h00;
  logic [7:0]            trk_stall = 8'h00;
  logic                  trk_wheel = 1'b0;
  logic [LIM_W-1:0]      lim_x = X_LIMIT_RST;
  logic [LIM_W-1:0]      lim_y = Y_LIMIT_RST;
  logic [TMO_W-1:0]      tmo_ticks = TIMEOUT_RST;

  report_t pending_reports [$];
  int mismatches = 0;
  int snd_pct = 0;
  int rcv_pct = 0;
  int tick_run = 0;

  ps2_mouse_packet_tracker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pointer_x_o      (pointer_x_o),
    .pointer_y_o      (pointer_y_o),
    .wheel_z_o        (wheel_z_o),
    .button_byte_o    (button_byte_o),
    .packet_done_o    (packet_done_o),
    .four_byte_mode_o (four_byte_mode_o),
    .resync_o         (resync_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [OUT_POS_W-1:0] clip_to(input int v, input logic [LIM_W-1:0] lim);
    int top;
    top = int'(lim);
    if (top > int'(POS_MAX)) top = int'(POS_MAX);
    if (v < 0) v = 0;
    if (v > top) v = top;
    return OUT_POS_W'(v);
  endfunction

  task automatic track_mouse_item(input logic op, input logic [7:0] b, output report_t r);
    int dx;
    int dy;
    int plen;
    plen = trk_wheel ? 4 : 3;
    r = '0;
    if (op == OP_BYTE) begin
      if (int'(trk_index) + 1 >= plen) begin
        dx = int'(trk_held[1]) - (trk_held[0][X_SIGN_BIT] ? 256 : 0);
        dy = int'(trk_held[2]) - (trk_held[0][Y_SIGN_BIT] ? 256 : 0);
        if (trk_wheel) trk_z = trk_z + {{12{b[3]}}, b[3:0]};
        trk_buttons = trk_held[0];
        trk_x = clip_to(int'(trk_x) + dx, lim_x);
        trk_y = clip_to(int'(trk_y) - dy, lim_y);
        trk_stall = 8'h00;
        trk_index = 2'd0;
        r.done = 1'b1;
      end else begin
        trk_held[trk_index] = b;
        trk_index = trk_index + 2'd1;
      end
    end else if (trk_index != 2'd0) begin
      if (trk_stall != 8'hFF) trk_stall = trk_stall + 8'd1;
      if (trk_stall >= tmo_ticks) begin
        trk_index = 2'd0;
        trk_stall = 8'h00;
        trk_wheel = ~trk_wheel;
        r.drop = 1'b1;
      end
    end
    r.px = trk_x;
    r.py = trk_y;
    r.wz = trk_z;
    r.btn = trk_buttons;
    r.wmode = trk_wheel;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // on the clock edge: check a result transaction, then roll the receiver stall
  task automatic step();
    report_t want;
    @(posedge clk_i);
    if (out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with nothing pending", 0, 0);
      end else begin
        want = pending_reports.pop_front();
        if (pointer_x_o !== want.px) flag_mismatch("pointer_x", pointer_x_o, want.px);
        if (pointer_y_o !== want.py) flag_mismatch("pointer_y", pointer_y_o, want.py);
        if (wheel_z_o !== want.wz)
          flag_mismatch("wheel_z", $signed(wheel_z_o), $signed(want.wz));
        if (button_byte_o !== want.btn) flag_mismatch("button_byte", button_byte_o, want.btn);
        if (packet_done_o !== want.done)
          flag_mismatch("packet_done", packet_done_o, want.done);
        if (four_byte_mode_o !== want.wmode)
          flag_mismatch("four_byte_mode", four_byte_mode_o, want.wmode);
        if (resync_o !== want.drop) flag_mismatch("resync", resync_o, want.drop);
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= rcv_pct);
  endtask

  task automatic wait_drained();
    while (pending_reports.size() != 0) step();
  endtask

  // caller drops cfg_valid_i after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do step(); while (!(cfg_valid_i && cfg_ready_o));
    case (idx)
      REG_X_LIMIT: lim_x = val[LIM_W-1:0];
      REG_Y_LIMIT: lim_y = val[LIM_W-1:0];
      REG_TIMEOUT: tmo_ticks = val[TMO_W-1:0];
      default: ;
    endcase
  endtask

  // mostly random packets; tick bursts long enough to hit the timeout
  task automatic pick_random(output logic op, output logic [7:0] b);
    if (tick_run == 0 && trk_index != 2'd0 && $urandom_range(0, 29) == 0)
      tick_run = (tmo_ticks == 8'd0 ? 1 : int'(tmo_ticks)) + int'($urandom_range(0, 2));
    if (tick_run > 0) begin
      op = OP_TICK;
      tick_run--;
    end else begin
      op = ($urandom_range(0, 9) == 0) ? OP_TICK : OP_BYTE;
    end
    case ($urandom_range(0, 7))
      0: b = 8'h00;
      1: b = 8'hFF;
      default: b = 8'($urandom_range(0, 255));
    endcase
  endtask

  task automatic send_items(input int n, input bit use_rows);
    int issued;
    int taken;
    logic op;
    logic [7:0] data;
    report_t got;
    issued = 0;
    taken = 0;
    while (taken < n) begin
      step();
      if (in_valid_i && in_ready_o) begin
        track_mouse_item(opcode_i, data_byte_i, got);
        if (use_rows && ROWS[taken].typed) got = ROWS[taken].want;
        pending_reports.push_back(got);
        taken++;
      end
      if (in_valid_i && !in_ready_o) begin
      end else if (issued < n && $urandom_range(0, 99) >= snd_pct) begin
        if (use_rows) begin
          op = ROWS[issued].op;
          data = ROWS[issued].data;
        end else begin
          pick_random(op, data);
        end
        in_valid_i <= 1'b1;
        opcode_i <= op;
        data_byte_i <= data;
        issued++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(REG_TIMEOUT, 12'd2);
    cfg_valid_i <= 1'b0;
    send_items(NUM_ROWS, 1'b1);
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_reg(REG_X_LIMIT, PH_XLIM[p]);
      write_reg(REG_Y_LIMIT, PH_YLIM[p]);
      write_reg(REG_TIMEOUT, PH_TMO[p]);
      if (p == 4) write_reg(REG_SPARE, 12'hAAA);
      cfg_valid_i <= 1'b0;
      snd_pct = PH_SND[p];
      rcv_pct = PH_RCV[p];
      tick_run = 0;
      send_items(PH_ITEMS[p], 1'b0);
    end
    wait_drained();
    repeat (4) step();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/ps2mt_pkg.sv
sv/ps2_mouse_packet_tracker.sv
sv/ps2mt_checker.sv
dv/testbench.sv
